FILE: hdl/olist_pkg.sv
// olist_pkg: shared constants, codes and types of the ordered list engine
// used by olist_ctrl, olist_dpath and ordered_list_engine; no dependencies
package olist_pkg;

  // list capacity and field widths
  localparam int unsigned CAPACITY  = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 8;

  // command codes; the two highest codes are ignored
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 3'd0,
    FN_APPEND = 3'd1,
    FN_REMOVE = 3'd2,
    FN_TAIL   = 3'd3,
    FN_DELETE = 3'd4,
    FN_SEARCH = 3'd5
  } func_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;   // capture the incoming command
    logic exec;   // apply the command and register the result
  } dp_cmd_t;

endpackage

FILE: hdl/olist_ctrl.sv
// olist_ctrl: controller of the ordered list engine, owns the handshakes
// depends on olist_pkg
module olist_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output olist_pkg::dp_cmd_t cmd_o
);
  import olist_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait until the result register is free
        if (!out_valid_q || m_ready_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign m_valid_o = out_valid_q;

endmodule

FILE: hdl/olist_dpath.sv
// olist_dpath: entry cells, entry count, compare and shift logic, result register
// depends on olist_pkg
module olist_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  olist_pkg::dp_cmd_t              cmd_i,
  input  logic [olist_pkg::FUNC_W-1:0]    func_i,
  input  logic [olist_pkg::DATA_W-1:0]    value_i,
  input  logic [olist_pkg::POS_W-1:0]     position_i,
  output logic [olist_pkg::STAT_W-1:0]    status_o,
  output logic                            found_o,
  output logic [olist_pkg::LEN_W-1:0]     length_o
);
  import olist_pkg::*;

  // command registers
  func_e              func_q;
  logic [DATA_W-1:0]  val_q;
  logic [POS_W-1:0]   pos_q;

  // entry cells and count
  logic [CAPACITY-1:0][DATA_W-1:0] entries_q, entries_d, ent_up, ent_dn;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // result register
  status_e            status_q, status_d;
  logic               found_q, found_d;
  logic [LEN_W-1:0]   length_q;

  // per-cell match and first-match masks
  logic [CAPACITY-1:0] match, first_hit, from_hit;
  logic                hit;
  logic                do_ins, do_rm, use_hit;
  logic [CMP_W-1:0]    pos_x, cnt_x, ins_at, rm_at;

  // capture the command
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(func_i);
      val_q  <= value_i;
      pos_q  <= position_i;
    end
  end

  // entry cells and result register, written when the command is applied
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      entries_q <= entries_d;
      status_q  <= status_d;
      found_q   <= found_d;
      length_q  <= LEN_W'(cnt_d);
    end
  end

  // entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_q <= cnt_d;
    end
  end

  // neighbor views of the cells for shifting
  assign ent_up = {entries_q[CAPACITY-2:0], DATA_W'(0)};
  assign ent_dn = {DATA_W'(0), entries_q[CAPACITY-1:1]};

  // compare in every cell, then isolate the first match
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (entries_q[i] == val_q) && (CMP_W'(i) < CMP_W'(cnt_q));
    end
    first_hit = match & (~match + 1'b1);
    from_hit  = ~(first_hit - 1'b1);
    hit       = |match;
  end

  // command decode
  always_comb begin
    pos_x    = CMP_W'(pos_q);
    cnt_x    = CMP_W'(cnt_q);
    do_ins   = 1'b0;
    do_rm    = 1'b0;
    use_hit  = 1'b0;
    ins_at   = cnt_x;
    rm_at    = pos_x - 1'b1;
    cnt_d    = cnt_q;
    status_d = ST_NOCHANGE;
    found_d  = 1'b0;
    case (func_q)
      FN_INSERT: begin
        if ((pos_x != '0) && (pos_x <= cnt_x + 1'b1)) begin
          if (cnt_q == CNT_W'(CAPACITY)) begin
            status_d = ST_FULL;
          end else begin
            do_ins   = 1'b1;
            ins_at   = pos_x - 1'b1;
            cnt_d    = cnt_q + 1'b1;
            status_d = ST_DONE;
          end
        end
      end
      FN_APPEND: begin
        if (cnt_q == CNT_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else begin
          do_ins   = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          status_d = ST_DONE;
        end
      end
      FN_REMOVE: begin
        if ((pos_x != '0) && (pos_x <= cnt_x)) begin
          do_rm    = 1'b1;
          cnt_d    = cnt_q - 1'b1;
          status_d = ST_DONE;
        end
      end
      FN_TAIL: begin
        if (cnt_q != '0) begin
          cnt_d    = cnt_q - 1'b1;
          status_d = ST_DONE;
        end
      end
      FN_DELETE: begin
        if (hit) begin
          do_rm    = 1'b1;
          use_hit  = 1'b1;
          cnt_d    = cnt_q - 1'b1;
          status_d = ST_DONE;
          found_d  = 1'b1;
        end
      end
      FN_SEARCH: begin
        if (hit) begin
          status_d = ST_DONE;
          found_d  = 1'b1;
        end
      end
      default: begin
        status_d = ST_NOCHANGE;
      end
    endcase
  end

  // per-cell load, shift up to open a slot, shift down to close one
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_d[i] = entries_q[i];
      if (do_ins) begin
        if (CMP_W'(i) == ins_at) begin
          entries_d[i] = val_q;
        end else if (CMP_W'(i) > ins_at) begin
          entries_d[i] = ent_up[i];
        end
      end else if (do_rm) begin
        if (use_hit ? from_hit[i] : (CMP_W'(i) >= rm_at)) begin
          entries_d[i] = ent_dn[i];
        end
      end
    end
  end

  assign status_o = status_q;
  assign found_o  = found_q;
  assign length_o = length_q;

endmodule

FILE: hdl/ordered_list_engine.sv
// ordered_list_engine: top level of the ordered list engine
// depends on olist_pkg, olist_ctrl and olist_dpath
//
// Keeps an ordered list of up to CAPACITY (16) signed 32-bit values in a row
// of register cells and takes one command per input transaction: insert at a
// 1-based position, append, remove at a position, remove the tail, delete the
// first equal value, or search. Every command returns one result transaction
// with status, found flag and the new length. A command is captured in S_IDLE
// and applied in S_EXEC, where every cell compares with the value and shifts
// up or down in parallel. A new command is accepted while the previous result
// still waits in the output register; the apply cycle waits until that
// register is free. The count is cleared by reset; there is no clearing pass.
module ordered_list_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [2:0] func, [34:3] value, [42:35] position, [47:43] zero
  input  logic [olist_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [1:0] status, [2] found, [7:3] length
  output logic [olist_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import olist_pkg::*;

  dp_cmd_t            dp_cmd;
  logic [STAT_W-1:0]  status;
  logic               found;
  logic [LEN_W-1:0]   length;

  // controller
  olist_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .cmd_o     (dp_cmd)
  );

  // datapath
  olist_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .func_i     (s_axis_tdata[FUNC_W-1:0]),
    .value_i    (s_axis_tdata[FUNC_W+DATA_W-1:FUNC_W]),
    .position_i (s_axis_tdata[FUNC_W+DATA_W+POS_W-1:FUNC_W+DATA_W]),
    .status_o   (status),
    .found_o    (found),
    .length_o   (length)
  );

  // result packing, the three fields fill the byte exactly
  assign m_axis_tdata = {length, found, status};

  // a command is never accepted in back-to-back cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("command accepted while the previous one is still applied");

  // a new result only appears after the apply cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised outside the apply cycle");

  // found implies a completed command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && found) |-> (status == ST_DONE))
    else $error("found flag with a status other than done");

endmodule

FILE: tb/ordered_list_engine_tb.sv
// ordered_list_engine_tb: self-checking testbench for the ordered list engine
// drives command transactions, predicts status/found/length from a list model
// depends on olist_pkg and ordered_list_engine
`timescale 1ns / 1ps

module ordered_list_engine_tb;
  import olist_pkg::*;

  // unused command codes, ignored by the engine
  localparam logic [FUNC_W-1:0] FN_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD7 = 3'd7;

  localparam logic [31:0] INT_MIN_V = 32'h8000_0000;
  localparam logic [31:0] INT_MAX_V = 32'h7fff_ffff;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  // result fields from the lowest bit up: status, found, length
  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic              found;
    logic [STAT_W-1:0] status;
  } list_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  // model list contents and expected results in transaction order
  logic [DATA_W-1:0] list_entries[$];
  list_result_t      pending_results[$];

  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           src_idle_pct = 0;
  int           snk_idle_pct = 0;
  list_result_t want_res;
  list_result_t got_res;

  ordered_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // gap length: mostly none or short, now and then long
  function automatic int idle_len(input int pct);
    int r;
    if (int'($urandom_range(99)) >= pct) return 0;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // apply one command to the list model and return the result it gives
  function automatic list_result_t list_cmd_result(input logic [FUNC_W-1:0] fn,
                                                   input logic [DATA_W-1:0] val,
                                                   input logic [POS_W-1:0]  pos);
    list_result_t res;
    int           hit;
    int           len;
    res.status = ST_NOCHANGE;
    res.found  = 1'b0;
    len        = list_entries.size();
    hit        = -1;
    foreach (list_entries[i])
      if (hit < 0 && list_entries[i] == val) hit = i;
    case (fn)
      FN_INSERT: begin
        // range check comes before the full check
        if (pos >= 1 && int'(pos) <= len + 1) begin
          if (len >= CAPACITY) begin
            res.status = ST_FULL;
          end else begin
            list_entries.insert(int'(pos) - 1, val);
            res.status = ST_DONE;
          end
        end
      end
      FN_APPEND: begin
        if (len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_entries.push_back(val);
          res.status = ST_DONE;
        end
      end
      FN_REMOVE: begin
        if (pos >= 1 && int'(pos) <= len) begin
          list_entries.delete(int'(pos) - 1);
          res.status = ST_DONE;
        end
      end
      FN_TAIL: begin
        if (len > 0) begin
          void'(list_entries.pop_back());
          res.status = ST_DONE;
        end
      end
      FN_DELETE: begin
        if (hit >= 0) begin
          list_entries.delete(hit);
          res.status = ST_DONE;
          res.found  = 1'b1;
        end
      end
      FN_SEARCH: begin
        if (hit >= 0) begin
          res.status = ST_DONE;
          res.found  = 1'b1;
        end
      end
      default: ;
    endcase
    res.length = LEN_W'(list_entries.size());
    return res;
  endfunction

  // send one command transaction; tvalid stays high when no gap follows
  task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    int gap;
    gap = idle_len(src_idle_pct);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, pos, val, fn};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(list_cmd_result(fn, val, pos));
  endtask

  // result side backpressure
  initial begin : result_stall
    int hold;
    int n;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        n = idle_len(snk_idle_pct);
        if (n > 0) begin
          m_axis_tready <= 1'b0;
          hold = n - 1;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = m_axis_tdata;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none got %h", $time, got_res);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.status !== want_res.status) begin
          mismatch_count++;
          $display("%0t: status mismatch, expected %0d got %0d", $time,
                   want_res.status, got_res.status);
        end
        if (got_res.found !== want_res.found) begin
          mismatch_count++;
          $display("%0t: found mismatch, expected %0d got %0d", $time,
                   want_res.found, got_res.found);
        end
        if (got_res.length !== want_res.length) begin
          mismatch_count++;
          $display("%0t: length mismatch, expected %0d got %0d", $time,
                   want_res.length, got_res.length);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // commands on an empty list, bad positions and unused codes
  task automatic test_empty_list();
    send_cmd(FN_TAIL, 32'd0, 8'd0);
    send_cmd(FN_REMOVE, 32'd0, 8'd1);
    send_cmd(FN_SEARCH, 32'd0, 8'd0);
    send_cmd(FN_DELETE, INT_MIN_V, 8'd0);
    send_cmd(FN_INSERT, 32'd5, 8'd0);
    send_cmd(FN_INSERT, 32'd5, 8'd2);
    send_cmd(FN_RSVD6, 32'hffff_ffff, 8'hff);
    send_cmd(FN_RSVD7, 32'd0, 8'd1);
  endtask

  // inserts, removals, duplicates and value extremes on a short list
  task automatic test_edit_ops();
    send_cmd(FN_INSERT, INT_MIN_V, 8'd1);
    send_cmd(FN_APPEND, INT_MAX_V, 8'd0);
    send_cmd(FN_INSERT, 32'd0, 8'd2);
    send_cmd(FN_INSERT, 32'hffff_ffff, 8'd4);
    send_cmd(FN_APPEND, 32'd0, 8'hff);
    send_cmd(FN_INSERT, 32'd9, 8'hff);
    send_cmd(FN_REMOVE, 32'd0, 8'd0);
    send_cmd(FN_REMOVE, 32'd0, 8'd6);
    send_cmd(FN_SEARCH, 32'd0, 8'd0);
    send_cmd(FN_SEARCH, 32'd12345, 8'd0);
    // first of two equal entries goes
    send_cmd(FN_DELETE, 32'd0, 8'd0);
    send_cmd(FN_DELETE, 32'd7, 8'd0);
    send_cmd(FN_REMOVE, 32'd0, 8'd1);
    send_cmd(FN_TAIL, 32'd0, 8'd0);
    send_cmd(FN_SEARCH, INT_MAX_V, 8'd0);
    send_cmd(FN_RSVD7, 32'd0, 8'd0);
    send_cmd(FN_REMOVE, 32'd0, POS_W'(list_entries.size()));
  endtask

  // fill to capacity, refused inserts, then drain to empty
  task automatic test_full_list();
    while (list_entries.size() < CAPACITY) send_cmd(FN_APPEND, $urandom, 8'd0);
    send_cmd(FN_INSERT, 32'd1, 8'd0);
    send_cmd(FN_INSERT, 32'd1, POS_W'(CAPACITY + 2));
    send_cmd(FN_INSERT, 32'd1, POS_W'(CAPACITY + 1));
    send_cmd(FN_INSERT, 32'd1, 8'd1);
    send_cmd(FN_APPEND, 32'd1, 8'd0);
    send_cmd(FN_SEARCH, list_entries[CAPACITY-1], 8'd0);
    send_cmd(FN_REMOVE, 32'd0, POS_W'(CAPACITY));
    send_cmd(FN_INSERT, 32'd3, POS_W'(CAPACITY));
    while (list_entries.size() > 0) send_cmd(FN_TAIL, 32'd0, 8'd0);
    send_cmd(FN_TAIL, 32'd0, 8'd0);
  endtask

  // value: often one already in the list, corners, small duplicates
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40 && list_entries.size() > 0)
      return list_entries[$urandom_range(list_entries.size() - 1)];
    if (r < 55) begin
      case ($urandom_range(4))
        0: return INT_MIN_V;
        1: return INT_MAX_V;
        2: return 32'hffff_ffff;
        3: return 32'd1;
        default: return 32'd0;
      endcase
    end
    if (r < 75) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  // position: mostly in range, sometimes zero, one past, or anything
  function automatic logic [POS_W-1:0] pick_pos(input int limit);
    int r;
    r = $urandom_range(99);
    if (r < 80 && limit > 0) return POS_W'($urandom_range(1, limit));
    if (r < 88) return '0;
    if (r < 95) return POS_W'(limit + 1);
    return POS_W'($urandom_range(255));
  endfunction

  // random commands in segments that drift the length up or down
  task automatic test_random_ops(input int n_items);
    int                drift;
    int                w_add;
    int                w_rem;
    int                r;
    logic [FUNC_W-1:0] fn;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        drift = $urandom_range(2);
        case ($urandom_range(2))
          0: src_idle_pct = 0;
          1: src_idle_pct = 30;
          default: src_idle_pct = 70;
        endcase
        case ($urandom_range(2))
          0: snk_idle_pct = 0;
          1: snk_idle_pct = 30;
          default: snk_idle_pct = 70;
        endcase
      end
      w_add = (drift == 0) ? 60 : (drift == 1) ? 15 : 35;
      w_rem = (drift == 1) ? 60 : (drift == 0) ? 15 : 35;
      r = $urandom_range(99);
      if (r < w_add) begin
        fn = $urandom_range(1) ? FN_INSERT : FN_APPEND;
      end else if (r < w_add + w_rem) begin
        case ($urandom_range(2))
          0: fn = FN_REMOVE;
          1: fn = FN_TAIL;
          default: fn = FN_DELETE;
        endcase
      end else if (r < 97) begin
        fn = FN_SEARCH;
      end else begin
        fn = $urandom_range(1) ? FN_RSVD6 : FN_RSVD7;
      end
      case (fn)
        FN_INSERT: send_cmd(fn, pick_value(), pick_pos(list_entries.size() + 1));
        FN_REMOVE: send_cmd(fn, $urandom, pick_pos(list_entries.size()));
        default:   send_cmd(fn, pick_value(), POS_W'($urandom_range(255)));
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_empty_list();
    src_idle_pct = 40;
    snk_idle_pct = 40;
    test_edit_ops();
    test_full_list();
    test_random_ops(1450);

    // let every result come back
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: ordered_list_engine.f
hdl/olist_pkg.sv
hdl/olist_ctrl.sv
hdl/olist_dpath.sv
hdl/ordered_list_engine.sv
tb/ordered_list_engine_tb.sv
